FILE: sv/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared constants and types for the chassis feedback frame parser: frame
// layout, frame IDs, result kinds and the decoded result record.
// ----------------------------------------------------------------------------
package cfp_pkg;

   localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
   localparam logic [3:0]  POS_ID_HI   = 4'd6;
   localparam logic [3:0]  POS_ID_LO   = 4'd7;
   localparam logic [3:0]  POS_PAYLOAD = 4'd8;
   localparam logic [3:0]  POS_LAST    = 4'd15;

   localparam logic [15:0] ID_ODOMETER = 16'h0311;
   localparam logic [15:0] ID_WHEEL_RF = 16'h0250;
   localparam logic [15:0] ID_WHEEL_LR = 16'h0253;
   localparam logic [15:0] ID_CMD_ECHO = 16'h0221;

   localparam logic [1:0]  KIND_ODOM   = 2'd0;
   localparam logic [1:0]  KIND_WHEEL  = 2'd1;
   localparam logic [1:0]  KIND_CMD    = 2'd2;

   typedef struct packed {
      logic        hit;
      logic [1:0]  frame_kind;
      logic [1:0]  wheel;
      logic [31:0] value_a;
      logic [31:0] value_b;
   } result_type;

endpackage

FILE: sv/chassis_feedback_frame_parser_top.sv
// ----------------------------------------------------------------------------
// chassis_feedback_frame_parser_top
// Parses 16-byte feedback frames from a serial byte stream and emits one
// decoded odometer, wheel or command echo record per frame with a known ID.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                           | tuser
//  req     | in        | [7:0] rx_byte                   | -
//  rsp     | out       | [31:0] value_a, [63:32] value_b | [1:0] frame_kind, [3:2] wheel
//
//  One byte per cycle while req_tready is high; a byte is parsed in the cycle it is transferred and a
//  result sits in the output register from the next cycle.
//  The output register is the only stage, so req_tready follows rsp_tready
//  whenever a result is held.
//  Reset returns the parser to waiting for sync and empties the output.
// ----------------------------------------------------------------------------
module chassis_feedback_frame_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] value_a, [63:32] value_b
   output logic [3:0]  rsp_tuser    // [1:0] frame_kind, [3:2] wheel
);
   import cfp_pkg::*;

   logic        in_frame_ff, in_frame_in;
   logic [3:0]  pos_ff, pos_in;
   logic [15:0] id_ff, id_in;
   logic [63:0] payload_ff, payload_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;
   result_type  dec;
   logic        accept;
   logic        frame_end;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign frame_end  = in_frame_ff && (pos_ff == POS_LAST);

   // Parse state update
   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      id_in       = id_ff;
      payload_in  = payload_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            if (req_tdata == SYNC_BYTE) begin
               in_frame_in = 1'b1;
               pos_in      = 4'd1;
               id_in       = '0;
               payload_in  = '0;
            end
         end else begin
            if (pos_ff == POS_ID_HI) begin
               id_in = {req_tdata, id_ff[7:0]};
            end else if (pos_ff == POS_ID_LO) begin
               id_in = {id_ff[15:8], req_tdata};
            end else if (pos_ff >= POS_PAYLOAD) begin
               payload_in = {payload_ff[55:0], req_tdata};
            end
            if (frame_end) begin
               in_frame_in = 1'b0;
               pos_in      = '0;
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end
      end
   end

   // The last byte is always payload, so decode from the shifted-in value
   cfp_decode u_decode (
      .msg_id   (id_ff),
      .payload  ({payload_ff[55:0], req_tdata}),
      .result   (dec)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in = frame_end && dec.hit;
         rsp_in       = dec;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      payload_ff <= payload_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.value_b, rsp_ff.value_a};
   assign rsp_tuser  = {rsp_ff.wheel, rsp_ff.frame_kind};

endmodule

FILE: sv/cfp_decode.sv
// ----------------------------------------------------------------------------
// cfp_decode
// Decodes a completed frame from its ID and 8-byte payload into one result
// record; hit is low for an unknown ID.
// ----------------------------------------------------------------------------
module cfp_decode (
   input  logic [15:0]         msg_id,
   input  logic [63:0]         payload,
   output cfp_pkg::result_type result
);
   import cfp_pkg::*;

   logic [31:0] hi_word;
   logic [31:0] lo_word;
   logic [15:0] wheel_ofs;

   assign hi_word   = payload[63:32];
   assign lo_word   = payload[31:0];
   assign wheel_ofs = msg_id - ID_WHEEL_RF;

   always_comb begin
      result = '0;
      if (msg_id == ID_ODOMETER) begin
         result.hit        = 1'b1;
         result.frame_kind = KIND_ODOM;
         result.value_a    = hi_word;
      end else if (msg_id inside {[ID_WHEEL_RF:ID_WHEEL_LR]}) begin
         result.hit        = 1'b1;
         result.frame_kind = KIND_WHEEL;
         result.wheel      = wheel_ofs[1:0];
         result.value_a    = {16'd0, hi_word[31:16]};
         result.value_b    = lo_word;
      end else if (msg_id == ID_CMD_ECHO) begin
         result.hit        = 1'b1;
         result.frame_kind = KIND_CMD;
         result.value_a    = {16'd0, hi_word[31:16]};
         result.value_b    = {16'd0, hi_word[15:0]};
      end
   end

endmodule

FILE: sv/cfp_checker.sv
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks for the chassis feedback frame parser, bound to the top.
// ----------------------------------------------------------------------------
module cfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);
   import cfp_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A new result only follows a byte transfer
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without input transfer");

   a_odom_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_ODOM
         |-> rsp_tuser[3:2] == 2'd0 && rsp_tdata[63:32] == 32'd0)
      else $error("odometer result has stray fields");

   a_narrow_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == KIND_WHEEL || rsp_tuser[1:0] == KIND_CMD)
         |-> rsp_tdata[31:16] == 16'd0)
      else $error("16-bit value overflows");

   a_cmd_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_CMD
         |-> rsp_tuser[3:2] == 2'd0 && rsp_tdata[63:48] == 16'd0)
      else $error("command echo result has stray fields");

endmodule

bind chassis_feedback_frame_parser_top cfp_checker u_cfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
